// ----- rtl/sfd_pkg.sv -----
// Shared types and constants of the sensor frame deframer.
// Used by sfd_framer, sfd_adc_scale and sensor_frame_deframer_top; no dependencies.
`default_nettype none

package sfd_pkg;

    // Framing
    localparam logic [7:0] HDR_FIRST    = 8'hAA;
    localparam logic [7:0] HDR_SECOND   = 8'hBB;
    localparam int         BODY_PAYLOAD = 11;   // frame bytes 2..12
    localparam int         ID_BYTES     = 4;    // node id bytes at the head of the payload
    localparam int         NODE_MOD     = 10000;

    // ADC estimate scaling
    localparam int TEMP_OFFSET = 4000;
    localparam int ADC_FULL    = 4095;
    localparam int TEMP_SPAN   = 12500;
    localparam int HUM_SPAN    = 10000;

    // Reciprocals for the constant divides: q ~= (p * RECIP) >> RECIP_SHIFT
    localparam int                    RECIP_SHIFT   = 40;
    localparam int                    RECIP_W       = 27;
    localparam longint unsigned       TEMP_RECIP_LI = (64'd1 << RECIP_SHIFT) / TEMP_SPAN;
    localparam longint unsigned       HUM_RECIP_LI  = (64'd1 << RECIP_SHIFT) / HUM_SPAN;
    localparam logic [RECIP_W-1:0]    TEMP_RECIP    = TEMP_RECIP_LI[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0]    HUM_RECIP     = HUM_RECIP_LI[RECIP_W-1:0];

    // Configuration port
    localparam int         CFG_INDEX_W = 3;
    localparam int         CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_MIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_MAX   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_MAX    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_MIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_MAX = 3'd4;

    localparam logic signed [15:0] TEMP_MIN_RST   = -16'sd5000;
    localparam logic signed [15:0] TEMP_MAX_RST   = 16'sd10000;
    localparam logic [15:0]        HUM_MAX_RST    = 16'd10000;
    localparam logic [15:0]        SUPPLY_MIN_RST = 16'd2000;
    localparam logic [15:0]        SUPPLY_MAX_RST = 16'd5000;

    // Framer view of the frame in flight
    typedef struct packed {
        logic               at_check;     // next body byte is the checksum
        logic [7:0]         xor_sum;
        logic [31:0]        node_id;
        logic [13:0]        node_short;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic [15:0]        supply;
        logic [7:0]         status;
    } frame_t;

endpackage

`default_nettype wire

// ----- rtl/sfd_framer.sv -----
// Header hunt, body byte collection, running XOR and node id modulo.
// Depends on sfd_pkg.
`default_nettype none

module sfd_framer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic [7:0]    rx_byte,
    output sfd_pkg::frame_t    frame
);
    import sfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_GOT_AA,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  xor_reg, xor_next;
    logic [13:0] mod_reg, mod_next;
    logic        wr_en;
    logic [7:0]  payload_reg [0:BODY_PAYLOAD-1];

    // (r*256 + b) mod 10000 for r < 10000, by restoring subtracts
    function automatic logic [13:0] mod_step(input logic [13:0] r, input logic [7:0] b);
        logic [21:0] x;
        logic [21:0] d;
        x = {r, b};
        for (int k = 7; k >= 0; k--) begin
            d = 22'(NODE_MOD) << k;
            if (x >= d)
                x = x - d;
        end
        return x[13:0];
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        mod_next   = mod_reg;
        wr_en      = 1'b0;
        if (in_fire)
        begin
            case (phase_reg)
                PH_GOT_AA:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_BODY;
                        cnt_next   = '0;
                        xor_next   = '0;
                        mod_next   = '0;
                    end
                    else if (rx_byte != HDR_FIRST)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    if (cnt_reg < 4'(BODY_PAYLOAD))
                    begin
                        wr_en    = 1'b1;
                        xor_next = xor_reg ^ rx_byte;
                        cnt_next = cnt_reg + 4'd1;
                        if (cnt_reg < 4'(ID_BYTES))
                            mod_next = mod_step(mod_reg, rx_byte);
                    end
                    else
                    begin
                        // checksum byte: frame done either way
                        phase_next = PH_HUNT;
                        cnt_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == HDR_FIRST) ? PH_GOT_AA : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
            xor_reg   <= '0;
            mod_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            mod_reg   <= mod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            payload_reg[cnt_reg] <= rx_byte;
    end

    always_comb
    begin
        frame.at_check    = (phase_reg == PH_BODY) && (cnt_reg == 4'(BODY_PAYLOAD));
        frame.xor_sum     = xor_reg;
        frame.node_id     = {payload_reg[0], payload_reg[1], payload_reg[2], payload_reg[3]};
        frame.node_short  = mod_reg;
        frame.temperature = {payload_reg[4], payload_reg[5]};
        frame.humidity    = {payload_reg[6], payload_reg[7]};
        frame.supply      = {payload_reg[8], payload_reg[9]};
        frame.status      = payload_reg[10];
    end

endmodule

`default_nettype wire

// ----- rtl/sfd_adc_scale.sv -----
// Free-running three-stage pipeline for the temperature and humidity ADC estimates.
// Constant divides by reciprocal multiply plus one correction. Depends on sfd_pkg.
`default_nettype none

module sfd_adc_scale (
    input  wire logic               clk,
    input  wire logic signed [15:0] temperature,
    input  wire logic [15:0]        humidity,
    output logic signed [14:0]      temp_adc,
    output logic [14:0]             hum_adc
);
    import sfd_pkg::*;

    // temperature path, sign-magnitude so the quotient truncates toward zero
    logic signed [16:0] t_off;
    logic [16:0]        t_mag;
    logic [28:0]        t_scaled;
    logic [54:0]        t_recip_prod;
    logic [29:0]        t_back_prod;
    logic [27:0]        t_rem;
    logic [14:0]        t_quot;

    logic        t_neg1_reg, t_neg2_reg, t_neg3_reg;
    logic [27:0] t_p1_reg, t_p2_reg, t_p3_reg;
    logic [13:0] t_qe2_reg, t_qe3_reg;
    logic [27:0] t_bk3_reg;

    // humidity path
    logic [27:0] h_scaled;
    logic [54:0] h_recip_prod;
    logic [28:0] h_back_prod;
    logic [27:0] h_rem;

    logic [27:0] h_p1_reg, h_p2_reg, h_p3_reg;
    logic [14:0] h_qe2_reg, h_qe3_reg;
    logic [27:0] h_bk3_reg;

    always_comb
    begin
        t_off        = 17'(temperature) + 17'sd4000;
        t_mag        = t_off[16] ? 17'(-t_off) : 17'(t_off);
        t_scaled     = {t_mag, 12'b0} - 29'(t_mag);          // * 4095
        t_recip_prod = 55'(t_p1_reg) * 55'(TEMP_RECIP);
        t_back_prod  = 30'(t_qe2_reg) * 30'(TEMP_SPAN);
        t_rem        = t_p3_reg - t_bk3_reg;
        t_quot       = 15'(t_qe3_reg) + ((t_rem >= 28'(TEMP_SPAN)) ? 15'd1 : 15'd0);
        temp_adc     = t_neg3_reg ? -$signed(t_quot) : $signed(t_quot);

        h_scaled     = {humidity, 12'b0} - 28'(humidity);    // * 4095
        h_recip_prod = 55'(h_p1_reg) * 55'(HUM_RECIP);
        h_back_prod  = 29'(h_qe2_reg) * 29'(HUM_SPAN);
        h_rem        = h_p3_reg - h_bk3_reg;
        hum_adc      = h_qe3_reg + ((h_rem >= 28'(HUM_SPAN)) ? 15'd1 : 15'd0);
    end

    always_ff @(posedge clk)
    begin
        t_neg1_reg <= t_off[16];
        t_p1_reg   <= t_scaled[27:0];
        t_neg2_reg <= t_neg1_reg;
        t_p2_reg   <= t_p1_reg;
        t_qe2_reg  <= t_recip_prod[RECIP_SHIFT +: 14];
        t_neg3_reg <= t_neg2_reg;
        t_p3_reg   <= t_p2_reg;
        t_qe3_reg  <= t_qe2_reg;
        t_bk3_reg  <= t_back_prod[27:0];

        h_p1_reg   <= h_scaled;
        h_p2_reg   <= h_p1_reg;
        h_qe2_reg  <= h_recip_prod[RECIP_SHIFT +: 15];
        h_p3_reg   <= h_p2_reg;
        h_qe3_reg  <= h_qe2_reg;
        h_bk3_reg  <= h_back_prod[27:0];
    end

endmodule

`default_nettype wire

// ----- rtl/sensor_frame_deframer_top.sv -----
// Top level of the sensor frame deframer: config registers, frame checks, result register.
// Depends on sfd_pkg, sfd_framer and sfd_adc_scale.
//
// Channel   Direction  Handshake              Carries
// --------  ---------  ---------------------  ---------------------------------------------
// in        sink       in_valid / in_ready    rx_byte, one received byte per request
// out       source     out_valid / out_ready  node_id, node_short, temperature_centi,
//                                             humidity_centi, supply_mv, status_byte,
//                                             temp_adc_estimate, humidity_adc_estimate
// cfg       sink       cfg_wr_en (no wait)    cfg_index, cfg_wdata (limit registers)
//
// One byte is taken every cycle that in_ready is high. A result is registered at the edge
// that takes the checksum byte and is offered on the next cycle; the three-stage ADC
// scaling pipeline is settled by then, since four or more bytes follow the humidity bytes.
// Reset (rst_n low, async) returns the framer to the header hunt, drops any pending
// result and loads the default limits.
// in_ready drops only when the next byte is a checksum and the result register is full
// and not being drained; every other byte is taken while a result waits.
`default_nettype none

module sensor_frame_deframer_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          rx_byte,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [31:0]                              node_id,
    output logic [13:0]                              node_short,
    output logic signed [15:0]                       temperature_centi,
    output logic [15:0]                              humidity_centi,
    output logic [15:0]                              supply_mv,
    output logic [7:0]                               status_byte,
    output logic signed [14:0]                       temp_adc_estimate,
    output logic [14:0]                              humidity_adc_estimate,

    input  wire logic                                cfg_wr_en,
    input  wire logic [sfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import sfd_pkg::*;

    // limit registers
    logic signed [15:0] temp_min_reg;
    logic signed [15:0] temp_max_reg;
    logic [15:0]        hum_max_reg;
    logic [15:0]        supply_min_reg;
    logic [15:0]        supply_max_reg;

    frame_t             frame;
    logic signed [14:0] temp_adc;
    logic [14:0]        hum_adc;

    logic in_fire;
    logic frame_ok;
    logic result_load;

    logic out_valid_reg, out_valid_next;

    // result register payload
    logic [31:0]        node_id_reg;
    logic [13:0]        node_short_reg;
    logic signed [15:0] temp_reg;
    logic [15:0]        hum_reg;
    logic [15:0]        supply_reg;
    logic [7:0]         status_reg;
    logic signed [14:0] temp_adc_reg;
    logic [14:0]        hum_adc_reg;

    sfd_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .rx_byte (rx_byte),
        .frame   (frame)
    );

    sfd_adc_scale u_adc_scale (
        .clk         (clk),
        .temperature (frame.temperature),
        .humidity    (frame.humidity),
        .temp_adc    (temp_adc),
        .hum_adc     (hum_adc)
    );

    // Only a checksum byte can create a result, so only it waits on a full output.
    assign in_ready = !(frame.at_check && out_valid_reg && !out_ready);
    assign in_fire  = in_valid && in_ready;

    // Inclusive limits; crossed limits reject every frame naturally.
    always_comb
    begin
        frame_ok = (rx_byte == frame.xor_sum)
                && (frame.temperature >= temp_min_reg)
                && (frame.temperature <= temp_max_reg)
                && (frame.humidity <= hum_max_reg)
                && (frame.supply >= supply_min_reg)
                && (frame.supply <= supply_max_reg);
        result_load = in_fire && frame.at_check && frame_ok;

        if (result_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            temp_min_reg   <= TEMP_MIN_RST;
            temp_max_reg   <= TEMP_MAX_RST;
            hum_max_reg    <= HUM_MAX_RST;
            supply_min_reg <= SUPPLY_MIN_RST;
            supply_max_reg <= SUPPLY_MAX_RST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TEMP_MIN:   temp_min_reg   <= cfg_wdata;
                    REG_TEMP_MAX:   temp_max_reg   <= cfg_wdata;
                    REG_HUM_MAX:    hum_max_reg    <= cfg_wdata;
                    REG_SUPPLY_MIN: supply_min_reg <= cfg_wdata;
                    REG_SUPPLY_MAX: supply_max_reg <= cfg_wdata;
                    default:        ;   // unmapped index, write dropped
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            node_id_reg    <= frame.node_id;
            node_short_reg <= frame.node_short;
            temp_reg       <= frame.temperature;
            hum_reg        <= frame.humidity;
            supply_reg     <= frame.supply;
            status_reg     <= frame.status;
            temp_adc_reg   <= temp_adc;
            hum_adc_reg    <= hum_adc;
        end
    end

    assign out_valid             = out_valid_reg;
    assign node_id               = node_id_reg;
    assign node_short            = node_short_reg;
    assign temperature_centi     = temp_reg;
    assign humidity_centi        = hum_reg;
    assign supply_mv             = supply_reg;
    assign status_byte           = status_reg;
    assign temp_adc_estimate     = temp_adc_reg;
    assign humidity_adc_estimate = hum_adc_reg;

endmodule

`default_nettype wire

// ----- bench/sfd_result_checker.sv -----
// Result checker for sensor_frame_deframer_top: follows the byte stream, predicts each reading
// and compares it with the out channel. Depends on sfd_pkg only.
module sfd_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [31:0]                     node_id,
    input  logic [13:0]                     node_short,
    input  logic signed [15:0]              temperature_centi,
    input  logic [15:0]                     humidity_centi,
    input  logic [15:0]                     supply_mv,
    input  logic [7:0]                      status_byte,
    input  logic signed [14:0]              temp_adc_estimate,
    input  logic [14:0]                     humidity_adc_estimate,
    input  logic                            cfg_wr_en,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_BODY} hunt_t;

    typedef struct packed {
        logic [31:0] id;
        logic [13:0] id_short;
        logic [15:0] temp;
        logic [15:0] hum;
        logic [15:0] supply;
        logic [7:0]  status;
        logic [14:0] temp_adc;
        logic [14:0] hum_adc;
    } reading_t;

    hunt_t              hunt;
    logic [3:0]         body_count;
    logic [7:0]         running_xor;
    logic [7:0]         body_bytes [BODY_PAYLOAD];
    logic signed [15:0] temp_lo, temp_hi;
    logic [15:0]        hum_hi, supply_lo, supply_hi;
    reading_t           readings_due [$];

    assign results_due = readings_due.size();

    initial begin
        fail_count = 0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Checksum byte arrived: check it and the field ranges, and queue the reading if all pass.
    task automatic close_frame(input logic [7:0] check);
        reading_t r;
        int       t;
        int       tadc;
        int       hadc;
        if (check != running_xor)
            return;
        r.id     = {body_bytes[0], body_bytes[1], body_bytes[2], body_bytes[3]};
        r.temp   = {body_bytes[4], body_bytes[5]};
        r.hum    = {body_bytes[6], body_bytes[7]};
        r.supply = {body_bytes[8], body_bytes[9]};
        r.status = body_bytes[10];
        t = int'($signed(r.temp));
        if (t < int'(temp_lo) || t > int'(temp_hi))
            return;
        if (r.hum > hum_hi)
            return;
        if (r.supply < supply_lo || r.supply > supply_hi)
            return;
        // SV integer divide truncates toward zero, as the scaling requires
        tadc = ((t + TEMP_OFFSET) * ADC_FULL) / TEMP_SPAN;
        hadc = (int'(r.hum) * ADC_FULL) / HUM_SPAN;
        r.id_short = 14'(r.id % NODE_MOD);
        r.temp_adc = 15'(tadc);
        r.hum_adc  = 15'(hadc);
        readings_due.push_back(r);
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        case (hunt)
            SEEK_SECOND: begin
                if (b == HDR_SECOND) begin
                    hunt        = IN_BODY;
                    body_count  = '0;
                    running_xor = '0;
                end
                else if (b != HDR_FIRST) begin
                    hunt = SEEK_FIRST;
                end
            end
            IN_BODY: begin
                // no resync mid-frame: header bytes here are plain data
                if (body_count < BODY_PAYLOAD) begin
                    body_bytes[body_count] = b;
                    running_xor            = running_xor ^ b;
                    body_count             = body_count + 1'b1;
                end
                else begin
                    close_frame(b);
                    hunt       = SEEK_FIRST;
                    body_count = '0;
                end
            end
            default: begin
                if (b == HDR_FIRST)
                    hunt = SEEK_SECOND;
                else
                    hunt = SEEK_FIRST;
            end
        endcase
    endtask

    task automatic check_reading();
        reading_t want;
        if (readings_due.size() == 0) begin
            report_mismatch("reading delivered with none expected");
            return;
        end
        want = readings_due.pop_front();
        check_field("node_id", node_id, want.id);
        check_field("node_short", 32'(node_short), 32'(want.id_short));
        check_field("temperature_centi", 32'($unsigned(temperature_centi)), 32'(want.temp));
        check_field("humidity_centi", 32'(humidity_centi), 32'(want.hum));
        check_field("supply_mv", 32'(supply_mv), 32'(want.supply));
        check_field("status_byte", 32'(status_byte), 32'(want.status));
        check_field("temp_adc_estimate", 32'($unsigned(temp_adc_estimate)),
                    32'(want.temp_adc));
        check_field("humidity_adc_estimate", 32'(humidity_adc_estimate), 32'(want.hum_adc));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hunt        = SEEK_FIRST;
            body_count  = '0;
            running_xor = '0;
            foreach (body_bytes[i])
                body_bytes[i] = '0;
            temp_lo   = TEMP_MIN_RST;
            temp_hi   = TEMP_MAX_RST;
            hum_hi    = HUM_MAX_RST;
            supply_lo = SUPPLY_MIN_RST;
            supply_hi = SUPPLY_MAX_RST;
            readings_due.delete();
        end
        else begin
            // out first: a reading leaving now never belongs to the byte taken now
            if (out_valid && out_ready)
                check_reading();
            if (in_valid && in_ready)
                absorb_byte(rx_byte);
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEMP_MIN:   temp_lo   = cfg_wdata;
                    REG_TEMP_MAX:   temp_hi   = cfg_wdata;
                    REG_HUM_MAX:    hum_hi    = cfg_wdata;
                    REG_SUPPLY_MIN: supply_lo = cfg_wdata;
                    REG_SUPPLY_MAX: supply_hi = cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- bench/tb_sensor_frame_deframer_top.sv -----
// Testbench top for sensor_frame_deframer_top: byte stream stimulus, limit register
// phases and the verdict. Depends on sfd_pkg, the RTL top and sfd_result_checker.
module tb_sensor_frame_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    // Indexes past the last limit register; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_SUPPLY_MAX + 1'b1;
    // Result register plus the three-stage ADC pipeline, with margin.
    localparam int SETTLE_CYCLES = 8;

    logic                   clk;
    logic                   rst_n;

    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             rx_byte;

    logic                   out_valid;
    logic                   out_ready;
    logic [31:0]            node_id;
    logic [13:0]            node_short;
    logic signed [15:0]     temperature_centi;
    logic [15:0]            humidity_centi;
    logic [15:0]            supply_mv;
    logic [7:0]             status_byte;
    logic signed [14:0]     temp_adc_estimate;
    logic [14:0]            humidity_adc_estimate;

    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int fail_count;
    int results_due;

    // Chance in percent that a side holds off in a given cycle.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Stimulus copy of the limits, used only to aim field values at the ranges.
    int cur_tmin, cur_tmax, cur_hmax, cur_smin, cur_smax;
    int bytes_sent = 0;

    sensor_frame_deframer_top u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .rx_byte               (rx_byte),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .node_id               (node_id),
        .node_short            (node_short),
        .temperature_centi     (temperature_centi),
        .humidity_centi        (humidity_centi),
        .supply_mv             (supply_mv),
        .status_byte           (status_byte),
        .temp_adc_estimate     (temp_adc_estimate),
        .humidity_adc_estimate (humidity_adc_estimate),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata)
    );

    sfd_result_checker u_checker (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .rx_byte               (rx_byte),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .node_id               (node_id),
        .node_short            (node_short),
        .temperature_centi     (temperature_centi),
        .humidity_centi        (humidity_centi),
        .supply_mv             (supply_mv),
        .status_byte           (status_byte),
        .temp_adc_estimate     (temp_adc_estimate),
        .humidity_adc_estimate (humidity_adc_estimate),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .fail_count            (fail_count),
        .results_due           (results_due)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: out_ready is redrawn every cycle from the current idle rate.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #1ms;
        $display("tb: failure");
        $finish;
    end

    // One request on the in channel. Idle cycles drop in_valid first; once raised,
    // valid and the byte hold until in_ready is seen at an edge. in_ready is read
    // right after the edge, before any update of that edge lands.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Full 14-byte frame: header, eleven payload bytes, checksum. A nonzero
    // flip corrupts the checksum.
    task automatic send_frame(input logic [31:0] id, input logic [15:0] temp,
                              input logic [15:0] hum, input logic [15:0] sup,
                              input logic [7:0] status, input logic [7:0] flip);
        logic [7:0] body [BODY_PAYLOAD];
        logic [7:0] check;
        body  = '{id[31:24], id[23:16], id[15:8], id[7:0], temp[15:8], temp[7:0],
                  hum[15:8], hum[7:0], sup[15:8], sup[7:0], status};
        check = '0;
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        foreach (body[i])
        begin
            check = check ^ body[i];
            push_byte(body[i]);
        end
        push_byte(check ^ flip);
    endtask

    // Mostly inside [lo, hi], often right on an edge, sometimes anywhere in the
    // field's span. Crossed limits just give span-wide values.
    function automatic int pick_bounded(input int lo, input int hi,
                                        input int span_lo, input int span_hi);
        int r;
        r = $urandom_range(99);
        if (lo > hi || r >= 85)
            return span_lo + int'($urandom_range(span_hi - span_lo));
        if (r < 8)
            return lo;
        if (r < 16)
            return hi;
        if (r < 22)
            return (lo > span_lo) ? lo - 1 : hi + 1;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Random traffic until the byte budget is spent: mostly well-formed frames
    // with random contents, plus line noise and broken headers.
    task automatic send_random_traffic(input int budget);
        int          stop_at;
        int          r;
        int          n;
        logic [31:0] id;
        logic [7:0]  junk;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                n = $urandom_range(4, 1);
                repeat (n) push_byte(8'($urandom));
            end
            else if (r < 14)
            begin
                // first header byte, then anything but a header byte
                junk = 8'($urandom);
                if (junk == HDR_FIRST || junk == HDR_SECOND)
                    junk = ~junk;
                push_byte(HDR_FIRST);
                push_byte(junk);
            end
            else
            begin
                if (r < 30)
                    push_byte(HDR_FIRST);   // repeated first header byte
                id = $urandom;
                case ($urandom_range(9))
                    0: id = '0;
                    1: id = '1;
                    2: id[31:16] = {HDR_FIRST, HDR_SECOND};   // header pattern in the body
                    default: ;
                endcase
                send_frame(id,
                           16'(pick_bounded(cur_tmin, cur_tmax, -32768, 32767)),
                           16'(pick_bounded(0, cur_hmax, 0, 65535)),
                           16'(pick_bounded(cur_smin, cur_smax, 0, 65535)),
                           8'($urandom),
                           ($urandom_range(99) < 8) ? 8'($urandom_range(255, 1)) : 8'h00);
            end
        end
    endtask

    // Stop sending, let every expected reading come out, then let the pipeline settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_wr_en high; the caller lowers it after the last write.
    task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // New limit set. Zero bytes first close any frame that noise may have opened,
    // so the block is back at the hunt and idle when the registers change.
    task automatic apply_limits(input int tmin, input int tmax, input int hmax,
                                input int smin, input int smax);
        repeat (BODY_PAYLOAD + 2) push_byte(8'h00);
        wait_drained();
        cfg_put(REG_TEMP_MIN, 16'(tmin));
        cfg_put(REG_TEMP_MAX, 16'(tmax));
        cfg_put(REG_HUM_MAX, 16'(hmax));
        cfg_put(REG_SUPPLY_MIN, 16'(smin));
        cfg_put(REG_SUPPLY_MAX, 16'(smax));
        // write past the register list last, so a decode fault would stick
        cfg_put(REG_SPARE_LO + CFG_INDEX_W'($urandom_range(2)), 16'($urandom));
        cfg_wr_en <= 1'b0;
        cur_tmin = tmin;
        cur_tmax = tmax;
        cur_hmax = hmax;
        cur_smin = smin;
        cur_smax = smax;
    endtask

    initial
    begin
        int t;
        int s;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_TEMP_MIN;
        cfg_wdata = '0;
        cur_tmin  = TEMP_MIN_RST;
        cur_tmax  = TEMP_MAX_RST;
        cur_hmax  = HUM_MAX_RST;
        cur_smin  = SUPPLY_MIN_RST;
        cur_smax  = SUPPLY_MAX_RST;

        // first idle mix: sender light, receiver heavy
        send_idle_pct = 14;
        recv_idle_pct = 77;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset limits:
        // broken header, then a repeated first header byte ahead of a frame whose
        // node id carries the header pattern and whose fields sit on the limits.
        push_byte(HDR_FIRST);
        push_byte(8'h55);
        push_byte(HDR_FIRST);
        send_frame(32'hAABB_AABB, TEMP_MIN_RST, HUM_MAX_RST, SUPPLY_MAX_RST,
                   HDR_FIRST, 8'h00);
        // other edges of the limits, node id zero
        send_frame(32'h0, TEMP_MAX_RST, 16'h0, SUPPLY_MIN_RST, HDR_SECOND, 8'h00);
        // good fields, bad checksum: dropped
        send_frame('1, 16'h0, 16'd5000, 16'd3300, 8'hFF, 8'h80);

        send_random_traffic(250);

        // wide open: every field extreme passes
        apply_limits(-32768, 32767, 65535, 0, 65535);
        send_random_traffic(300);

        // second idle mix: sender heavy, receiver light
        send_idle_pct = 77;
        recv_idle_pct = 14;

        t = -int'($urandom_range(32768));
        s = $urandom_range(30000);
        apply_limits(t, $urandom_range(32767), $urandom_range(65535), s,
                     s + int'($urandom_range(65535 - s)));
        send_random_traffic(350);

        // single-value windows, humidity only at zero
        t = int'($urandom_range(65535)) - 32768;
        s = $urandom_range(65535);
        apply_limits(t, t, 0, s, s);
        send_random_traffic(250);

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // crossed limits: nothing may pass
        apply_limits(100, -100, 65535, 5000, 4000);
        send_random_traffic(150);

        apply_limits(-32768, 32767, 65535, 0, 65535);
        send_random_traffic(200);

        // back to the reset values
        apply_limits(TEMP_MIN_RST, TEMP_MAX_RST, HUM_MAX_RST, SUPPLY_MIN_RST,
                     SUPPLY_MAX_RST);
        send_random_traffic(150);

        wait_drained();
        if (fail_count == 0 && results_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
